// ===== hdl/rational_arith_unit_top_defines.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH
// Implication check clocked on clk, off during reset.
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/rau_pkg.sv =====
// Shared codes and types of the rational arithmetic unit.
package rau_pkg;
	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_CMP  = 3'd5;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;
	localparam int MAG_W = 64;
	typedef logic [MAG_W-1:0] mag_t;
	typedef struct packed {
		logic start;
		mag_t x;
		mag_t y;
	} gcd_req_t;
	typedef struct packed {
		logic done;
		mag_t g;
	} gcd_rsp_t;
endpackage

// ===== hdl/rational_arith_unit_top.sv =====
// Rational arithmetic unit: normalize, add, subtract, multiply, divide, compare.
// Usage:
//   Input channel in_valid/in_stall carries req_type and both fractions.
//   Output channel out_valid/out_stall carries the reduced fraction, the
//   compare flags and status, one word per request.
//   Run time rests on the shared 64-bit bit-serial divider, which serves
//   each Euclid remainder step and the reduction divides. Errors skip
//   straight to the result. One request is in work at a time; in_stall is
//   high while busy or while a result waits.
//   When the receiver stalls, the result word holds until taken.
//   Reset clears the sequencer and drops any pending word.
module rational_arith_unit_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] req_type,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0] b_den,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic less,
	output logic equal,
	output logic greater,
	output logic [1:0] status
);
	logic busy_q, done;
	logic [31:0] c_num;
	logic [30:0] c_den;
	logic c_lt, c_eq, c_gt;
	logic [1:0] c_st;
	assign in_stall = busy_q || out_valid;
	rau_core #(.VALUE_WIDTH(VALUE_WIDTH)) u_core (
		.clk(clk), .arst_n(arst_n), .start(in_valid && !in_stall),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num),
		.b_den(b_den), .done(done), .res_num(c_num), .res_den(c_den),
		.less(c_lt), .equal(c_eq), .greater(c_gt), .status(c_st)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (done) begin
			res_num <= c_num;
			res_den <= c_den;
			less <= c_lt;
			equal <= c_eq;
			greater <= c_gt;
			status <= c_st;
		end
	end
endmodule

// ===== hdl/rau_divider.sv =====
// Shared radix-2 restoring divider: quotient and remainder, one bit per cycle.
module rau_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  rau_pkg::mag_t dividend,
	input  rau_pkg::mag_t divisor,
	output logic done,
	output rau_pkg::mag_t quot,
	output rau_pkg::mag_t rem
);
	import rau_pkg::*;
	logic busy_q;
	logic [6:0] cnt_q;
	mag_t q_q, r_q, d_q;
	logic [MAG_W:0] trial;
	assign trial = {r_q, q_q[MAG_W-1]} - {1'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				r_q <= trial[MAG_W-1:0];
				q_q <= {q_q[MAG_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[MAG_W-2:0], q_q[MAG_W-1]};
				q_q <= {q_q[MAG_W-2:0], 1'b0};
			end
		end
	end
	assign quot = q_q;
	assign rem = r_q;
endmodule

// ===== hdl/rau_core.sv =====
// Sequencer: cross products, Euclid gcd and reduction on the shared divider.
module rau_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [2:0] req_type,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [30:0] b_den,
	output logic done,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic less,
	output logic equal,
	output logic greater,
	output logic [1:0] status
);
	import rau_pkg::*;
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL1 = 9'b000000010,
		S_MUL2 = 9'b000000100,
		S_COMB = 9'b000001000,
		S_GCD  = 9'b000010000,
		S_GWT  = 9'b000100000,
		S_DN   = 9'b001000000,
		S_DD   = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;
	state_t state_q;
	logic [2:0] op_q;
	logic an_neg_q, bn_neg_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	mag_t p_q, q_q, d_q, x_q, y_q, nr_q;
	logic n_neg_q;
	logic [31:0] mul_a, mul_b;
	mag_t prod;
	logic dv_start, dv_done;
	mag_t dv_n, dv_d, dv_quot, dv_rem;
	logic [31:0] an_m, ad_m, bn_m;
	logic an_s, bad;
	mag_t lim;
	logic pend_q;
	assign lim = (mag_t'(1) << (VALUE_WIDTH - 1)) - mag_t'(1);
	assign an_m = a_num[31] ? 32'(-a_num) : a_num;
	assign ad_m = a_den[31] ? 32'(-a_den) : a_den;
	assign bn_m = b_num[31] ? 32'(-b_num) : b_num;
	assign an_s = (a_num[31] ^ a_den[31]) && (an_m != '0);
	assign bad = (req_type > OP_CMP) || (ad_m == '0)
		|| (req_type != OP_NORM && b_den == '0)
		|| (req_type == OP_DIV && bn_m == '0);
	assign prod = mag_t'(mul_a) * mag_t'(mul_b);
	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		if (state_q == S_MUL2) begin
			mul_a = ad_q;
			mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
		end else if (state_q == S_COMB) begin
			mul_a = bn_q;
			mul_b = ad_q;
		end else if (op_q == OP_MUL) begin
			mul_b = bn_q;
		end
	end
	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n),
		.divisor(dv_d), .done(dv_done), .quot(dv_quot), .rem(dv_rem)
	);
	assign dv_start = (state_q == S_GCD && y_q != '0 && x_q != '0)
		|| (state_q == S_DN && !pend_q && x_q != '0)
		|| (state_q == S_DD && !pend_q);
	always_comb begin
		dv_n = x_q;
		dv_d = y_q;
		if (state_q == S_DN) begin
			dv_n = p_q;
			dv_d = x_q;
		end else if (state_q == S_DD) begin
			dv_n = d_q;
			dv_d = x_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					if (bad) begin
						state_q <= S_OUT;
					end else if (req_type == OP_NORM) begin
						state_q <= S_GCD;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= (op_q == OP_CMP) ? S_COMB : S_MUL2;
				S_MUL2: state_q <= (op_q == OP_ADD || op_q == OP_SUB) ? S_COMB : S_GCD;
				S_COMB: state_q <= (op_q == OP_CMP) ? S_OUT : S_GCD;
				S_GCD: state_q <= (y_q == '0 || x_q == '0) ? S_DN : S_GWT;
				S_GWT: if (dv_done) state_q <= S_GCD;
				S_DN: begin
					if (x_q == '0) state_q <= S_OUT;
					else if (!pend_q) pend_q <= 1'b1;
					else if (dv_done) begin
						pend_q <= 1'b0;
						state_q <= S_DD;
					end
				end
				S_DD: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (dv_done) begin
						pend_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	logic [1:0] st_q;
	logic lt_q, eq_q, gt_q;
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				op_q <= req_type;
				an_q <= an_m;
				ad_q <= ad_m;
				bn_q <= bn_m;
				bd_q <= {1'b0, b_den};
				an_neg_q <= an_s;
				bn_neg_q <= b_num[31] && (bn_m != '0);
				st_q <= bad ? ST_ZERO : ST_OK;
				lt_q <= 1'b0; eq_q <= 1'b0; gt_q <= 1'b0;
				p_q <= mag_t'(an_m);
				d_q <= mag_t'(ad_m);
				x_q <= mag_t'(an_m);
				y_q <= mag_t'(ad_m);
				n_neg_q <= an_s;
			end
			S_MUL1: begin
				p_q <= prod;
				n_neg_q <= (op_q == OP_MUL || op_q == OP_DIV) ? (an_neg_q ^ bn_neg_q) : an_neg_q;
			end
			S_MUL2: begin
				d_q <= prod;
				x_q <= p_q;
				y_q <= prod;
			end
			S_COMB: begin
				if (op_q == OP_CMP) begin
					if (n_neg_q != bn_neg_q) begin
						lt_q <= n_neg_q; gt_q <= !n_neg_q;
					end else if (p_q == prod) begin
						eq_q <= 1'b1;
					end else begin
						lt_q <= (p_q > prod) == n_neg_q;
						gt_q <= (p_q > prod) != n_neg_q;
					end
				end else begin
					if ((n_neg_q == (bn_neg_q ^ (op_q == OP_SUB))) || p_q >= prod) begin
						p_q <= (n_neg_q == (bn_neg_q ^ (op_q == OP_SUB))) ? p_q + prod : p_q - prod;
						x_q <= (n_neg_q == (bn_neg_q ^ (op_q == OP_SUB))) ? p_q + prod : p_q - prod;
					end else begin
						p_q <= prod - p_q;
						x_q <= prod - p_q;
						n_neg_q <= bn_neg_q ^ (op_q == OP_SUB);
					end
					y_q <= d_q;
				end
			end
			S_GWT: if (dv_done) begin
				x_q <= y_q;
				y_q <= dv_rem;
			end
			S_DN: if (pend_q && dv_done) nr_q <= dv_quot;
			S_DD: if (pend_q && dv_done) begin
				if (nr_q > lim || dv_quot > lim) st_q <= ST_OVF;
				d_q <= dv_quot;
			end
			default: ;
		endcase
	end
	logic zero_q;
	always_ff @(posedge clk) begin
		if (state_q == S_DN) zero_q <= (x_q == '0);
	end
	logic ok_arith;
	assign ok_arith = (st_q == ST_OK) && (op_q != OP_CMP) && !zero_q;
	assign res_num = ok_arith ? (n_neg_q ? 32'(-nr_q) : nr_q[31:0]) : 32'd0;
	assign res_den = ok_arith ? d_q[30:0] : 31'd1;
	assign less = (st_q == ST_OK) && (op_q == OP_CMP) && lt_q;
	assign equal = (st_q == ST_OK) && (op_q == OP_CMP) && eq_q;
	assign greater = (st_q == ST_OK) && (op_q == OP_CMP) && gt_q;
	assign status = st_q;
	`include "rational_arith_unit_top_defines.svh"
	`RAU_ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q), "state not one-hot")
	`RAU_ASSERT_NEXT(a_done_idle, done, state_q == S_IDLE, "done outside idle")
	`RAU_ASSERT_IMPL(a_cmp_flags, done, $countones({less, equal, greater}) <= 1, "flags")
endmodule

// ===== verif/tb_rational_arith_unit_top.sv =====
// Self-checking testbench for the rational arithmetic unit: directed table plus random requests.
module tb_rational_arith_unit_top;
	import rau_pkg::*;

	localparam int VALUE_WIDTH = 32;

	typedef struct {
		logic signed [31:0] num;
		logic [30:0] den;
		logic lt;
		logic eq;
		logic gt;
		logic [1:0] st;
	} frac_res_t;

	typedef struct {
		logic [2:0] op;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [30:0] bd;
		bit typed;
		frac_res_t res;
	} req_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic signed [31:0] a_num = '0;
	logic signed [31:0] a_den = '0;
	logic signed [31:0] b_num = '0;
	logic [30:0] b_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic less;
	logic equal;
	logic greater;
	logic [1:0] status;

	frac_res_t pending_q[$];
	req_row_t dir_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_taken = 0;
	int n_err_words = 0;
	int n_cmp_words = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	rational_arith_unit_top #(.VALUE_WIDTH(VALUE_WIDTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den),
		.less(less), .equal(equal), .greater(greater), .status(status)
	);

	always #2 clk = ~clk;

	function automatic frac_res_t reduce_frac(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		logic an_s, ad_s, bn_s, q_s, n_s;
		logic [63:0] an_m, ad_m, bn_m, bd_m, p_m, q_m, n_m, d_m, t, u, r, lim;
		logic signed [65:0] sp, sq;
		frac_res_t res;
		res = '{num: '0, den: 31'd1, lt: 1'b0, eq: 1'b0, gt: 1'b0, st: ST_OK};
		an_s = an[31];
		ad_s = ad[31];
		bn_s = bn[31];
		an_m = an_s ? {32'b0, -an} : {32'b0, an};
		ad_m = ad_s ? {32'b0, -ad} : {32'b0, ad};
		bn_m = bn_s ? {32'b0, -bn} : {32'b0, bn};
		bd_m = {33'b0, bd};
		if (op > OP_CMP || ad_m == 0 || (op != OP_NORM && bd_m == 0)) begin
			res.st = ST_ZERO;
			return res;
		end
		if (ad_s)
			an_s = !an_s;
		if (an_m == 0)
			an_s = 1'b0;
		n_s = an_s;
		n_m = an_m;
		d_m = ad_m;
		case (op)
			OP_ADD, OP_SUB: begin
				p_m = an_m * bd_m;
				q_s = (op == OP_SUB) ? !bn_s : bn_s;
				q_m = bn_m * ad_m;
				if (an_s == q_s) begin
					n_m = p_m + q_m;
				end else if (p_m >= q_m) begin
					n_m = p_m - q_m;
				end else begin
					n_s = q_s;
					n_m = q_m - p_m;
				end
				if (n_m == 0)
					n_s = 1'b0;
				d_m = ad_m * bd_m;
			end
			OP_MUL: begin
				n_s = an_s ^ bn_s;
				n_m = an_m * bn_m;
				d_m = ad_m * bd_m;
			end
			OP_DIV: begin
				if (bn_m == 0) begin
					res.st = ST_ZERO;
					return res;
				end
				n_s = an_s ^ bn_s;
				n_m = an_m * bd_m;
				d_m = ad_m * bn_m;
			end
			OP_CMP: begin
				sp = $signed({2'b0, an_m * bd_m});
				sq = $signed({2'b0, bn_m * ad_m});
				if (an_s)
					sp = -sp;
				if (bn_s)
					sq = -sq;
				res.lt = sp < sq;
				res.eq = sp == sq;
				res.gt = sp > sq;
				return res;
			end
			default: ;
		endcase
		if (n_m == 0)
			return res;
		t = n_m;
		u = d_m;
		while (u != 0) begin
			r = t % u;
			t = u;
			u = r;
		end
		n_m = n_m / t;
		d_m = d_m / t;
		lim = (64'd1 << (VALUE_WIDTH - 1)) - 1;
		if (n_m > lim || d_m > lim) begin
			res.st = ST_OVF;
			return res;
		end
		res.num = n_s ? -n_m[31:0] : n_m[31:0];
		res.den = d_m[30:0];
		return res;
	endfunction

	function automatic req_row_t mk(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [30:0] bd, bit typed, logic [31:0] num, logic [30:0] den,
			logic lt, logic eq, logic gt, logic [1:0] st);
		req_row_t row;
		row = '{op: op, an: an, ad: ad, bn: bn, bd: bd, typed: typed,
			res: '{num: num, den: den, lt: lt, eq: eq, gt: gt, st: st}};
		return row;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0, 1: return 32'($signed($urandom_range(0, 200)) - 100);
			2: return $urandom;
			3: return 32'($signed($urandom_range(0, 2000)) - 1000) * 32'($urandom_range(1, 3000));
			4: begin
				case ($urandom_range(0, 5))
					0: return 32'h7fffffff;
					1: return 32'h80000001;
					2: return 32'h80000000;
					3: return 32'hffffffff;
					4: return 32'd1;
					default: return 32'd0;
				endcase
			end
			default: return 32'($urandom_range(1, 50)) << $urandom_range(0, 24);
		endcase
	endfunction

	task automatic send_word(req_row_t row);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= row.op;
		a_num <= row.an;
		a_den <= row.ad;
		b_num <= row.bn;
		b_den <= row.bd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_q.push_back(row.typed ? row.res
			: reduce_frac(row.op, row.an, row.ad, row.bn, row.bd));
		n_sent++;
	endtask

	task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected word, actual num %0h den %0h status %0d",
						$time, res_num, res_den, status);
					errors++;
				end else begin
					frac_res_t e;
					e = pending_q.pop_front();
					if (res_num !== e.num) report("res_num", e.num, res_num);
					if (res_den !== e.den) report("res_den", 32'(e.den), 32'(res_den));
					if (less !== e.lt) report("less", 32'(e.lt), 32'(less));
					if (equal !== e.eq) report("equal", 32'(e.eq), 32'(equal));
					if (greater !== e.gt) report("greater", 32'(e.gt), 32'(greater));
					if (status !== e.st) report("status", 32'(e.st), 32'(status));
					n_taken++;
					if (e.st != ST_OK) n_err_words++;
					if (e.lt || e.eq || e.gt) n_cmp_words++;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 99) < 30) begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#400_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		req_row_t row;
		int wait_cnt;
		dir_q.push_back(mk(OP_NORM, 6, -4, 0, 0, 1, -3, 2, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_NORM, 0, -5, 9, 3, 1, 0, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_NORM, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0, ST_ZERO));
		dir_q.push_back(mk(OP_NORM, 32'h7fffffff, 1, 0, 0, 1, 32'h7fffffff, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_NORM, 32'h80000000, 1, 0, 0, 1, 0, 1, 0, 0, 0, ST_OVF));
		dir_q.push_back(mk(OP_NORM, 32'h80000001, 32'h80000001, 0, 0, 1, 1, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_ADD, 1, 2, 1, 0, 1, 0, 1, 0, 0, 0, ST_ZERO));
		dir_q.push_back(mk(OP_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1, 1, 0, 1, 0, 0, 0, ST_OVF));
		dir_q.push_back(mk(OP_ADD, 32'h80000001, 32'h7fffffff, 32'h80000001, 31'h7ffffffe,
			0, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(mk(OP_SUB, 1, 2, 1, 2, 1, 0, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_SUB, 32'h80000001, 32'h7fffffff, 32'h7fffffff, 31'h7ffffffe,
			0, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(mk(OP_MUL, 32'h7fffffff, 1, 2, 1, 1, 0, 1, 0, 0, 0, ST_OVF));
		dir_q.push_back(mk(OP_MUL, -3, 4, 4, 3, 1, -1, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_MUL, 32'h7ffffffe, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
			0, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(mk(OP_DIV, 1, 2, 0, 1, 1, 0, 1, 0, 0, 0, ST_ZERO));
		dir_q.push_back(mk(OP_DIV, 3, 4, -3, 8, 1, -2, 1, 0, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_DIV, 3, 0, 5, 8, 1, 0, 1, 0, 0, 0, ST_ZERO));
		dir_q.push_back(mk(OP_CMP, 1, 2, 2, 4, 1, 0, 1, 0, 1, 0, ST_OK));
		dir_q.push_back(mk(OP_CMP, -1, 3, 1, 3, 1, 0, 1, 1, 0, 0, ST_OK));
		dir_q.push_back(mk(OP_CMP, 32'h7fffffff, 1, 32'h7fffffff, 31'h7fffffff,
			1, 0, 1, 0, 0, 1, ST_OK));
		dir_q.push_back(mk(OP_CMP, 1, -2, -1, 2, 1, 0, 1, 0, 1, 0, ST_OK));
		dir_q.push_back(mk(3'd6, 1, 1, 1, 1, 1, 0, 1, 0, 0, 0, ST_ZERO));
		dir_q.push_back(mk(3'd7, 1, 1, 1, 1, 1, 0, 1, 0, 0, 0, ST_ZERO));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_q[i])
			send_word(dir_q[i]);
		for (int k = 0; k < 1525; k++) begin
			if (k % 150 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			row.op = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			row.an = rand_val();
			row.ad = rand_val();
			row.bn = rand_val();
			row.bd = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'(rand_val());
			if ($urandom_range(0, 39) != 0 && row.ad == 0)
				row.ad = 1;
			if ($urandom_range(0, 39) != 0 && row.bd == 0)
				row.bd = 1;
			row.typed = 1'b0;
			send_word(row);
		end
		in_valid <= 1'b0;
		wait_cnt = 0;
		while (pending_q.size() != 0 && wait_cnt < 2_000_000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (pending_q.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, pending_q.size());
			errors++;
		end
		$display("Run covered %0d requests and %0d result words:", n_sent, n_taken);
		$display("%0d error or overflow words, %0d compare words.", n_err_words, n_cmp_words);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
